### src/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, calendar constants, month length lookup and the
// control/status bundles between the date adder controller and datapath.
// ----------------------------------------------------------------------------
package dad_pkg;

  // field widths
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int DAYS_IN_W = 16;

  // stream widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;

  // parameter defaults
  localparam int DEF_DAYS_WIDTH = 16;
  localparam int DEF_MAX_YEAR   = 9999;

  // calendar codes
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY_DEC = 5'd31;

  // year split into year mod 100 and the low bits of the century
  localparam int YMOD_W = 7;
  localparam int Q_W    = 8;
  localparam logic [YMOD_W-1:0] YMOD_LAST = 7'd99;
  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for y below 2**YEAR_W
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  HUNDRED     = 7'd100;

  // length of a month, leap selects the long february
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic init;      // split the year into century and year mod 100
    logic step;      // one walking step
    logic out_load;  // move the date into the output register
  } dad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;      // no days left or the year saturated
  } dad_status_t;

endpackage

### src/dad_ctrl.sv
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for the date adder: accepts a word, runs the walk until the
// datapath reports done, then hands the date to the output register.
// ----------------------------------------------------------------------------
module dad_ctrl
  import dad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  dad_status_t status,
  output dad_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INIT   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load     = s_tvalid && (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.done) state_next = ST_FINISH;
        else cmd.step = 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

endmodule

### src/dad_datapath.sv
// ----------------------------------------------------------------------------
// dad_datapath
// Date registers and the walking step: each step either jumps the day
// within the current month or rolls into the next month.
// ----------------------------------------------------------------------------
module dad_datapath
  import dad_pkg::*;
#(
  parameter int DAYS_WIDTH = DEF_DAYS_WIDTH,
  parameter int MAX_YEAR   = DEF_MAX_YEAR
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dad_cmd_t             cmd,
  input  logic [DAY_W-1:0]     start_day,
  input  logic [MONTH_W-1:0]   start_month,
  input  logic [YEAR_W-1:0]    start_year,
  input  logic [DAYS_IN_W-1:0] days_to_add,
  output dad_status_t          status,
  output logic [DAY_W-1:0]     result_day,
  output logic [MONTH_W-1:0]   result_month,
  output logic [YEAR_W-1:0]    result_year,
  output logic                 year_overflow
);

  // counter width also covers the 5-bit room value
  localparam int CW = (DAYS_WIDTH > DAY_W) ? DAYS_WIDTH : DAY_W;
  localparam logic [31:0] MAX_Y = MAX_YEAR;

  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [YMOD_W-1:0]  ymod;
  logic [1:0]         cent;
  logic [Q_W-1:0]     q;
  logic [CW-1:0]      n;
  logic               ovf;
  logic               halt;

  logic [CW-1:0]      n_load;
  logic [MONTH_W-1:0] m_clamp;
  logic [YEAR_W-1:0]  y_clamp;
  logic               y_big;
  logic [26:0]        y_prod;
  logic [14:0]        q_times;
  logic [14:0]        y_rem;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   room;
  logic [CW-1:0]      room_ext;
  logic               at_max;

  // only the low DAYS_WIDTH bits of the count take part
  always_comb begin
    n_load = '0;
    for (int i = 0; i < CW; i++) begin
      if (i < DAYS_WIDTH && i < DAYS_IN_W) n_load[i] = days_to_add[i];
    end
  end

  // clamp month and year of the incoming word
  assign y_big   = {{(32-YEAR_W){1'b0}}, start_year} > MAX_Y;
  assign y_clamp = y_big ? MAX_Y[YEAR_W-1:0] : start_year;
  always_comb begin
    if (start_month == '0) m_clamp = JANUARY;
    else if (start_month > DECEMBER) m_clamp = DECEMBER;
    else m_clamp = start_month;
  end

  // century by reciprocal multiply, remainder in the following cycle
  assign y_prod  = {13'd0, y_clamp} * {14'd0, RECIP_100};
  assign q_times = {7'd0, q} * {8'd0, HUNDRED};
  assign y_rem   = {1'b0, year} - q_times;

  // leap rule: year mod 100 zero means century divisible by four
  assign leap     = (ymod == '0) ? (cent == 2'd0) : (year[1:0] == 2'd0);
  assign len      = month_days(month, leap);
  assign room     = len - day;
  assign room_ext = {{(CW-DAY_W){1'b0}}, room};
  assign at_max   = {{(32-YEAR_W){1'b0}}, year} >= MAX_Y;

  assign status.done = (n == '0) || halt;

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      halt <= 1'b0;
    end else if (cmd.load) begin
      halt <= 1'b0;
    end else if (cmd.step && day >= len && month == DECEMBER && at_max) begin
      halt <= 1'b1;
    end
  end

  // date registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day   <= start_day;
      month <= m_clamp;
      year  <= y_clamp;
      ovf   <= y_big;
      n     <= n_load;
      q     <= y_prod[RECIP_SHIFT +: Q_W];
    end else if (cmd.init) begin
      ymod <= y_rem[YMOD_W-1:0];
      cent <= q[1:0];
    end else if (cmd.step) begin
      if (day >= len) begin
        // roll into the next month, or saturate on 31 December of the maximum year
        n   <= n - 1'b1;
        day <= FIRST_DAY;
        if (month == DECEMBER) begin
          if (at_max) begin
            ovf   <= 1'b1;
            day   <= LAST_DAY_DEC;
            year  <= MAX_Y[YEAR_W-1:0];
          end else begin
            year  <= year + 1'b1;
            month <= JANUARY;
            if (ymod == YMOD_LAST) begin
              ymod <= '0;
              cent <= cent + 1'b1;
            end else begin
              ymod <= ymod + 1'b1;
            end
          end
        end else begin
          month <= month + 1'b1;
        end
      end else if (n <= room_ext) begin
        // finish inside this month
        day <= day + n[DAY_W-1:0];
        n   <= '0;
      end else begin
        // jump to the last day of this month
        day <= len;
        n   <= n - room_ext;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_day    <= day;
      result_month  <= month;
      result_year   <= year;
      year_overflow <= ovf;
    end
  end

endmodule

### src/date_add_days_top.sv
// Sequence: the word is loaded, the year is split, then the walking steps run,
//   at most two per month crossed plus one, before the result is registered.
// Throughput: one word at a time; the next word is taken once the result is
//   in the output register.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// date_add_days_top
// Gregorian date adder: start date plus a day count, with year saturation.
// ----------------------------------------------------------------------------
module date_add_days_top
  import dad_pkg::*;
#(
  parameter int DAYS_WIDTH = DEF_DAYS_WIDTH,
  parameter int MAX_YEAR   = DEF_MAX_YEAR
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9]
  output logic [M_DATA_W-1:0] m_tdata,
  // year_overflow[0]
  output logic [0:0]          m_tuser
);

  dad_cmd_t           cmd;
  dad_status_t        status;
  logic [DAY_W-1:0]   result_day;
  logic [MONTH_W-1:0] result_month;
  logic [YEAR_W-1:0]  result_year;
  logic               year_overflow;

  // sequencer
  dad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // date datapath
  dad_datapath #(
    .DAYS_WIDTH (DAYS_WIDTH),
    .MAX_YEAR   (MAX_YEAR)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .start_day     (s_tdata[4:0]),
    .start_month   (s_tdata[8:5]),
    .start_year    (s_tdata[22:9]),
    .days_to_add   (s_tdata[38:23]),
    .status        (status),
    .result_day    (result_day),
    .result_month  (result_month),
    .result_year   (result_year),
    .year_overflow (year_overflow)
  );

  // pack result word
  assign m_tdata = {1'b0, result_year, result_month, result_day};
  assign m_tuser = year_overflow;

endmodule

### src/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks for the date adder, bound to the top level.
// ----------------------------------------------------------------------------
module dad_checker
  import dad_pkg::*;
#(
  parameter int MAX_YEAR = DEF_MAX_YEAR
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [0:0]          m_tuser
);

  localparam logic [31:0] MAX_Y = MAX_YEAR;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // one word in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

  // result month is always a real month
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= DECEMBER))
    else $error("result month out of range");

  // overflow only with the year saturated
  a_ovf_year: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> ({18'd0, m_tdata[22:9]} == MAX_Y))
    else $error("overflow without saturated year");

endmodule

bind date_add_days_top dad_checker #(
  .MAX_YEAR (MAX_YEAR)
) u_dad_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
